[hw/rtl/ub24_pkg.sv]
// ub24_pkg: shared types, constants and the chroma table function for the
// uyvy to bgr24 converter; depends on nothing
package ub24_pkg;

  localparam int CFG_W        = 13;    // width of a configuration register
  localparam int BYTE_W       = 8;
  localparam int TABLE_DEPTH  = 256;
  localparam int CHROMA_OFFSET = 128;
  localparam int MILLI_SCALE  = 1000;

  // chroma coefficients in thousandths
  localparam int K_RED_CR   = 1371;
  localparam int K_GREEN_CB = -336;
  localparam int K_GREEN_CR = -698;
  localparam int K_BLUE_CB  = 1732;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] chroma_blue;
    logic [7:0] luma_first;
    logic [7:0] chroma_red;
    logic [7:0] luma_second;
  } uyvy_word_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       frame_end;
  } bgr_pair_t;

  typedef struct packed {
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       frame_end;
  } raster_flags_t;

  // fixed-point chroma term, truncated toward zero; used at elaboration only
  function automatic longint chroma_term(int milli, int code, int frac);
    longint d;
    d = longint'(code) - longint'(CHROMA_OFFSET);
    return (longint'(milli) * d * (longint'(1) << frac)) / MILLI_SCALE;
  endfunction

endpackage

[hw/rtl/ub24_channel.sv]
// ub24_channel: one color channel, luma plus chroma term, rounded and clamped
// depends on ub24_pkg
module ub24_channel #(
  parameter int FRAC_BITS = 10
) (
  input  logic [7:0]                  luma,
  input  logic signed [FRAC_BITS+9:0] term,
  output logic [7:0]                  level
);
  import ub24_pkg::*;

  localparam int VW       = FRAC_BITS + 11;
  localparam int HALF_INT = 1 << (FRAC_BITS - 1);

  logic signed [VW-1:0] luma_scaled;
  logic signed [VW-1:0] sum;
  logic                 negative;
  logic                 overflow;

  assign luma_scaled = $signed({{(VW - BYTE_W - FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});
  assign sum         = luma_scaled + VW'(term) + VW'(HALF_INT);
  assign negative    = sum[VW-1];
  // anything at or above 256 after the shift
  assign overflow    = |sum[VW-2:FRAC_BITS+BYTE_W];

  always_comb begin
    priority if (negative) begin
      level = '0;
    end else if (overflow) begin
      level = '1;
    end else begin
      level = sum[FRAC_BITS+BYTE_W-1:FRAC_BITS];
    end
  end

endmodule

[hw/rtl/ub24_color_math.sv]
// ub24_color_math: chroma tables and the six channel datapaths of one pair
// depends on ub24_pkg and ub24_channel
module ub24_color_math #(
  parameter int FRAC_BITS = 10
) (
  input  ub24_pkg::uyvy_word_t    quad,
  input  ub24_pkg::raster_flags_t flags,
  output ub24_pkg::bgr_pair_t     pair,
  output logic                    width_ok
);
  import ub24_pkg::*;

  localparam int TW = FRAC_BITS + 10;

  logic signed [TW-1:0] red_tab      [TABLE_DEPTH];
  logic signed [TW-1:0] green_cb_tab [TABLE_DEPTH];
  logic signed [TW-1:0] green_cr_tab [TABLE_DEPTH];
  logic signed [TW-1:0] blue_tab     [TABLE_DEPTH];

  // constant tables, folded at elaboration
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_tab
    assign red_tab[i]      = TW'(chroma_term(K_RED_CR, i, FRAC_BITS));
    assign green_cb_tab[i] = TW'(chroma_term(K_GREEN_CB, i, FRAC_BITS));
    assign green_cr_tab[i] = TW'(chroma_term(K_GREEN_CR, i, FRAC_BITS));
    assign blue_tab[i]     = TW'(chroma_term(K_BLUE_CB, i, FRAC_BITS));
  end

  logic signed [TW-1:0] red_term;
  logic signed [TW-1:0] green_term;
  logic signed [TW-1:0] blue_term;

  assign red_term   = red_tab[quad.chroma_red];
  // combined magnitude stays well below the term range
  assign green_term = green_cb_tab[quad.chroma_blue] + green_cr_tab[quad.chroma_red];
  assign blue_term  = blue_tab[quad.chroma_blue];

  logic [7:0] b1, g1, r1, b2, g2, r2;

  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_b1 (.luma(quad.luma_first),  .term(blue_term),  .level(b1));
  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_g1 (.luma(quad.luma_first),  .term(green_term), .level(g1));
  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_r1 (.luma(quad.luma_first),  .term(red_term),   .level(r1));
  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_b2 (.luma(quad.luma_second), .term(blue_term),  .level(b2));
  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_g2 (.luma(quad.luma_second), .term(green_term), .level(g2));
  ub24_channel #(.FRAC_BITS(FRAC_BITS)) u_r2 (.luma(quad.luma_second), .term(red_term),   .level(r2));

  always_comb begin
    pair.blue_first   = b1;
    pair.green_first  = g1;
    pair.red_first    = r1;
    pair.blue_second  = b2;
    pair.green_second = g2;
    pair.red_second   = r2;
    pair.row_end      = flags.row_end;
    pair.pad_bytes    = flags.pad_bytes;
    pair.frame_end    = flags.frame_end;
  end

  // pad is only ever reported together with a row end
  assign width_ok = flags.row_end || (flags.pad_bytes == 2'd0);

endmodule

[hw/rtl/ub24_raster.sv]
// ub24_raster: frame size registers, pair and row counters, row and frame flags
// depends on ub24_pkg
module ub24_raster #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  ub24_pkg::cfg_reg_t           cfg_index,
  input  logic [ub24_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         advance,
  output ub24_pkg::raster_flags_t      flags
);
  import ub24_pkg::*;

  localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
  localparam int PAIR_W   = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WIDTH_RESET  = 800;
  localparam int HEIGHT_RESET = 600;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [PAIR_W-1:0] pair_column;
  logic [ROW_W-1:0]  row_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(WIDTH_RESET);
      image_height <= CFG_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective width: saturate, drop the low bit, at least one pair
  logic                width_over;
  logic [WIDTH_W-1:0]  width_sat;
  logic [WIDTH_W-1:0]  width_even;
  logic [WIDTH_W-1:0]  width_eff;
  logic [WIDTH_W-1:0]  pairs;

  assign width_over = {1'b0, image_width} > (CFG_W + 1)'(MAX_WIDTH);
  assign width_sat  = width_over ? WIDTH_W'(MAX_WIDTH) : WIDTH_W'(image_width);
  assign width_even = {width_sat[WIDTH_W-1:1], 1'b0};
  assign width_eff  = (width_even[WIDTH_W-1:1] == '0) ? WIDTH_W'(2) : width_even;
  assign pairs      = width_eff >> 1;

  // effective height: saturate, at least one row
  logic                height_over;
  logic [HEIGHT_W-1:0] height_sat;
  logic [HEIGHT_W-1:0] rows;

  assign height_over = {1'b0, image_height} > (CFG_W + 1)'(MAX_HEIGHT);
  assign height_sat  = height_over ? HEIGHT_W'(MAX_HEIGHT) : HEIGHT_W'(image_height);
  assign rows        = (height_sat == '0) ? HEIGHT_W'(1) : height_sat;

  logic [WIDTH_W-1:0]  pair_count;
  logic [HEIGHT_W-1:0] row_count;

  assign pair_count = WIDTH_W'(pair_column) + WIDTH_W'(1);
  assign row_count  = HEIGHT_W'(row_index) + HEIGHT_W'(1);

  always_comb begin
    flags.row_end   = pair_count >= pairs;
    flags.frame_end = flags.row_end && (row_count >= rows);
    // 3*w mod 4 is 2 exactly when bit 1 of the even width is set
    flags.pad_bytes = flags.row_end ? {width_eff[1], 1'b0} : 2'd0;
  end

  logic [PAIR_W-1:0] pair_column_next;
  logic [ROW_W-1:0]  row_index_next;

  always_comb begin
    priority if (flags.frame_end) begin
      pair_column_next = '0;
      row_index_next   = '0;
    end else if (flags.row_end) begin
      pair_column_next = '0;
      row_index_next   = row_index + ROW_W'(1);
    end else begin
      pair_column_next = pair_column + PAIR_W'(1);
      row_index_next   = row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
    end else if (advance) begin
      pair_column <= pair_column_next;
      row_index   <= row_index_next;
    end
  end

endmodule

[hw/rtl/uyvy_to_bgr24_converter.sv]
// uyvy_to_bgr24_converter: top level, input and result registers around the
// color datapath; depends on ub24_pkg, ub24_raster, ub24_color_math
//
// usage
//   quad channel (quad_valid / quad_ready / quad): one UYVY word per transfer,
//   Cb, first luma, Cr, second luma
//   pixels channel (pixels_valid / pixels_ready / pixels): one word per quad,
//   two BGR pixels plus row end, BMP pad byte count and frame end flags
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   image_width, index 1 is image_height; cfg_ready is always high, write
//   only while no word is in flight
// path: a quad accepted at an edge sits in the input register, then moves into
//   the result register, whose word is on pixels with pixels_valid high
// throughput: one word per clock; both sides run without bubbles as long as
//   pixels_ready stays high, limited only by the table lookup, chroma add and
//   clamp between the two registers
// reset (rst, synchronous): both stages empty, counters at the top of the
//   frame, width 800 and height 600
// stall: with pixels_ready low the result register holds, the input register
//   takes one more word, and quad_ready drops once both are full
module uyvy_to_bgr24_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int FRAC_BITS  = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        quad_valid,
  output logic                        quad_ready,
  input  ub24_pkg::uyvy_word_t        quad,
  output logic                        pixels_valid,
  input  logic                        pixels_ready,
  output ub24_pkg::bgr_pair_t         pixels,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  ub24_pkg::cfg_reg_t          cfg_index,
  input  logic [ub24_pkg::CFG_W-1:0]  cfg_data
);
  import ub24_pkg::*;

  // config writes are taken every cycle
  assign cfg_ready = 1'b1;

  logic          quad_accept;
  logic          s2_ready;
  raster_flags_t flags;

  // raster position is sampled at acceptance and travels with the word
  ub24_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_raster (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .advance  (quad_accept),
    .flags    (flags)
  );

  // input register
  logic          s1_valid;
  uyvy_word_t    s1_word;
  raster_flags_t s1_flags;

  assign s2_ready    = !pixels_valid || pixels_ready;
  assign quad_ready  = !s1_valid || s2_ready;
  assign quad_accept = quad_valid && quad_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (quad_ready) begin
      s1_valid <= quad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_accept) begin
      s1_word  <= quad;
      s1_flags <= flags;
    end
  end

  // color math between the two registers
  bgr_pair_t pair;
  logic      flags_ok;

  ub24_color_math #(.FRAC_BITS(FRAC_BITS)) u_math (
    .quad    (s1_word),
    .flags   (s1_flags),
    .pair    (pair),
    .width_ok(flags_ok)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_valid <= 1'b0;
    end else if (s2_ready) begin
      pixels_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      pixels <= pair;
    end
  end

`ifndef SYNTHESIS
  // a word waiting in the input register is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_word) && $stable(s1_flags))
    else $error("input register changed while stalled");

  // backpressure only when both stages are full and the result is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !quad_ready |-> s1_valid && pixels_valid && !pixels_ready)
    else $error("quad_ready low with room in the pipeline");

  // flags carried with the word stay consistent
  a_flags: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> flags_ok && (!s1_flags.frame_end || s1_flags.row_end))
    else $error("pad or frame end without row end");
`endif

endmodule
